[sv/spd_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the short packet deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package spd_pkg;

  // Frame delimiters
  localparam logic [7:0] START_BYTE = 8'd2;
  localparam logic [7:0] STOP_BYTE  = 8'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_CRC_POLY    = 2'd1;
  localparam logic [1:0] REG_CRC_INIT    = 2'd2;

  // Register reset values
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd255;
  localparam logic [15:0] CRC_POLY_RST    = 16'h1021;
  localparam logic [15:0] CRC_INIT_RST    = 16'h0000;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_CRC  = 2'd2,
    ST_STOP = 2'd3
  } status_e;

  // Configuration as seen by the front end
  typedef struct packed {
    logic [7:0]  max_payload;
    logic [15:0] crc_poly;
    logic [15:0] crc_init;
  } cfg_t;

  // Compact queue entry: value is the payload byte or the frame length
  typedef struct packed {
    logic        kind;
    logic [7:0]  value;
    status_e     status;
  } entry_t;

  // One byte through an MSB-first CRC-16, no reflection
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/spd_front.sv]
// Front end: accepts received bytes, tracks the frame phase and CRC, and
// pushes classified entries into the queue. Depends on spd_pkg.
`default_nettype none

module spd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire spd_pkg::cfg_t cfg_i,
  input  wire logic          rx_valid_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          q_full_i,
  output logic               rx_stall_o,
  output logic               push_o,
  output spd_pkg::entry_t    entry_o
);
  import spd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  exp_len_q, exp_len_d;
  logic [7:0]  seen_q, seen_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic        accept;
  logic [7:0]  seen_inc;
  logic [15:0] crc_next;
  logic        len_bad;
  logic        crc_bad;

  assign rx_stall_o = q_full_i;
  assign accept     = rx_valid_i && !q_full_i;
  assign seen_inc   = seen_q + 8'd1;
  assign crc_next   = crc_feed(crc_q, rx_byte_i, cfg_i.crc_poly);
  assign len_bad    = (rx_byte_i == 8'd0) || (rx_byte_i > cfg_i.max_payload);
  assign crc_bad    = {crc_hi_q, rx_byte_i} != crc_q;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        PH_HUNT:   if (rx_byte_i == START_BYTE) phase_d = PH_LEN;
        PH_LEN:    phase_d = len_bad ? PH_HUNT : PH_DATA;
        PH_DATA:   if (seen_inc >= exp_len_q) phase_d = PH_CRC_HI;
        PH_CRC_HI: phase_d = PH_CRC_LO;
        PH_CRC_LO: phase_d = crc_bad ? PH_HUNT : PH_STOP;
        PH_STOP:   phase_d = PH_HUNT;
        default:   phase_d = PH_HUNT;
      endcase
    end
  end

  // Queue push and entry contents
  always_comb begin
    push_o         = 1'b0;
    entry_o.kind   = KIND_DATA;
    entry_o.value  = rx_byte_i;
    entry_o.status = ST_OK;
    if (accept) begin
      case (phase_q)
        PH_LEN: begin
          if (len_bad) begin
            push_o         = 1'b1;
            entry_o.kind   = KIND_REPORT;
            entry_o.status = ST_LEN;
          end
        end
        PH_DATA: push_o = 1'b1;
        PH_CRC_LO: begin
          if (crc_bad) begin
            push_o         = 1'b1;
            entry_o.kind   = KIND_REPORT;
            entry_o.value  = exp_len_q;
            entry_o.status = ST_CRC;
          end
        end
        PH_STOP: begin
          push_o         = 1'b1;
          entry_o.kind   = KIND_REPORT;
          entry_o.value  = exp_len_q;
          entry_o.status = (rx_byte_i == STOP_BYTE) ? ST_OK : ST_STOP;
        end
        default: push_o = 1'b0;
      endcase
    end
  end

  // Frame datapath: length, count, CRC, saved high CRC byte
  always_comb begin
    exp_len_d = exp_len_q;
    seen_d    = seen_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    if (accept) begin
      case (phase_q)
        PH_LEN: begin
          exp_len_d = len_bad ? 8'd0 : rx_byte_i;
          seen_d    = 8'd0;
          crc_d     = len_bad ? 16'd0 : cfg_i.crc_init;
          crc_hi_d  = 8'd0;
        end
        PH_DATA: begin
          seen_d = seen_inc;
          crc_d  = crc_next;
        end
        PH_CRC_HI: crc_hi_d = rx_byte_i;
        PH_CRC_LO: begin
          if (crc_bad) begin
            exp_len_d = 8'd0;
            seen_d    = 8'd0;
            crc_d     = 16'd0;
            crc_hi_d  = 8'd0;
          end
        end
        PH_STOP: begin
          exp_len_d = 8'd0;
          seen_d    = 8'd0;
          crc_d     = 16'd0;
          crc_hi_d  = 8'd0;
        end
        default: begin
          exp_len_d = exp_len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      exp_len_q <= 8'd0;
      seen_q    <= 8'd0;
      crc_q     <= 16'd0;
      crc_hi_q  <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      seen_q    <= seen_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
    end
  end

endmodule

`default_nettype wire

[sv/spd_fifo.sv]
// Short entry queue between the front end and the output stage.
// Depends on spd_pkg for the entry type and depth.
`default_nettype none

module spd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire spd_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output spd_pkg::entry_t      head_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import spd_pkg::*;

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/spd_back.sv]
// Output stage: pops queue entries, expands them into result fields and
// holds them in the output register until transferred. Depends on spd_pkg.
`default_nettype none

module spd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire spd_pkg::entry_t head_i,
  output logic                 pop_o,
  output logic                 tx_valid_o,
  input  wire logic            tx_stall_i,
  output logic                 kind_o,
  output logic [7:0]           data_byte_o,
  output logic [1:0]           status_o,
  output logic [7:0]           frame_length_o,
  output logic                 last_o
);
  import spd_pkg::*;

  logic       valid_q;
  logic       kind_q;
  logic [7:0] data_q, len_q;
  logic [1:0] status_q;
  logic       load;
  logic       is_report;

  assign load      = !valid_q || !tx_stall_i;
  assign pop_o     = load && !q_empty_i;
  assign is_report = head_i.kind == KIND_REPORT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !q_empty_i;
    end
  end

  // Expand the entry into result fields
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= head_i.kind;
      data_q   <= is_report ? 8'd0 : head_i.value;
      len_q    <= is_report ? head_i.value : 8'd0;
      status_q <= is_report ? head_i.status : ST_OK;
    end
  end

  assign tx_valid_o     = valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign status_o       = status_q;
  assign frame_length_o = len_q;
  assign last_o         = kind_q;

endmodule

`default_nettype wire

[sv/short_packet_deframer_crc16.sv]
// Short packet deframer with CRC-16 check: top level with configuration port.
// A result is written into the queue when its byte is accepted, then loaded into the output register.
// Throughput: 1 byte per cycle; the front end stalls only when the 2-entry
// queue is full, which happens only while the output side stalls.
// Reset clears the frame phase, queue and output valid; registers take their
// reset values (max payload 255, polynomial 0x1021, start value 0).
`default_nettype none

module short_packet_deframer_crc16 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // received bytes
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // results
  output logic             tx_valid_o,
  input  wire logic        tx_stall_i,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [1:0]       status_o,
  output logic [7:0]       frame_length_o,
  output logic             last_o
);
  import spd_pkg::*;

  logic [7:0]  max_payload_q;
  logic [15:0] crc_poly_q, crc_init_q;
  cfg_t        cfg;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  logic        q_push, q_pop, q_full, q_empty;
  entry_t      q_entry, q_head;

  // Register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
      crc_poly_q    <= CRC_POLY_RST;
      crc_init_q    <= CRC_INIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_PAYLOAD: max_payload_q <= pwdata[7:0];
        REG_CRC_POLY:    crc_poly_q    <= pwdata[15:0];
        REG_CRC_INIT:    crc_init_q    <= pwdata[15:0];
        default:         max_payload_q <= max_payload_q;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_MAX_PAYLOAD: prdata = {24'd0, max_payload_q};
      REG_CRC_POLY:    prdata = {16'd0, crc_poly_q};
      REG_CRC_INIT:    prdata = {16'd0, crc_init_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.max_payload = max_payload_q;
  assign cfg.crc_poly    = crc_poly_q;
  assign cfg.crc_init    = crc_init_q;

  spd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .rx_stall_o (rx_stall_o),
    .push_o     (q_push),
    .entry_o    (q_entry)
  );

  spd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  spd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .tx_valid_o     (tx_valid_o),
    .tx_stall_i     (tx_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .status_o       (status_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("push into full queue");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("pop from empty queue");

  // A status report always closes a frame, a payload byte never does
  a_last_on_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o |-> (last_o == kind_o))
    else $error("last does not match result kind");

  // A payload byte carries no status or length
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && (kind_o == KIND_DATA)) |-> (status_o == ST_OK && frame_length_o == 8'd0))
    else $error("payload result carries report fields");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && tx_stall_i) |=> tx_valid_o)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

[tb/short_packet_deframer_crc16_tb.sv]
// Testbench for short_packet_deframer_crc16: streams framed and corrupt byte sequences
// under random valid/stall idling, predicts every payload byte and status report.
// Depends on spd_pkg and the short_packet_deframer_crc16 RTL.
`default_nettype none

module short_packet_deframer_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_STOP, FR_BAD_LEN, FR_CUT} frame_fault_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    status_e    status;
    logic [7:0] len;
    logic       last;
  } frame_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        tx_valid_o;
  logic        tx_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [1:0]  status_o;
  logic [7:0]  frame_length_o;
  logic        last_o;

  // Register copies as last written
  logic [7:0]  cfg_max  = MAX_PAYLOAD_RST;
  logic [15:0] cfg_poly = CRC_POLY_RST;
  logic [15:0] cfg_init = CRC_INIT_RST;

  // Deframer state as predicted
  phase_e      dp_phase  = PH_HUNT;
  logic [7:0]  dp_len    = '0;
  logic [7:0]  dp_seen   = '0;
  logic [15:0] dp_crc    = '0;
  logic [7:0]  dp_crc_hi = '0;

  logic [7:0]  rx_bytes_q[$];
  frame_out_t  frame_out_q[$];

  int unsigned idle_pct = 0;
  int unsigned rx_gap = 0;
  int unsigned tx_gap = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;

  short_packet_deframer_crc16 u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .tx_valid_o     (tx_valid_o),
    .tx_stall_i     (tx_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .status_o       (status_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // MSB-first CRC-16, one data bit per round
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0};
      if (fb) crc = crc ^ cfg_poly;
    end
    return crc;
  endfunction

  function automatic void drop_frame();
    dp_phase  = PH_HUNT;
    dp_len    = '0;
    dp_seen   = '0;
    dp_crc    = '0;
    dp_crc_hi = '0;
  endfunction

  // Advance the predicted deframer by one received byte
  function automatic void deframe_byte(logic [7:0] b);
    frame_out_t r;
    r = '{kind: KIND_REPORT, data: 8'd0, status: ST_OK, len: dp_len, last: 1'b1};
    case (dp_phase)
      PH_HUNT: if (b == START_BYTE) dp_phase = PH_LEN;
      PH_LEN: begin
        if (b == 8'd0 || b > cfg_max) begin
          r.status = ST_LEN;
          r.len = b;
          frame_out_q.push_back(r);
          drop_frame();
        end else begin
          dp_len   = b;
          dp_seen  = '0;
          dp_crc   = cfg_init;
          dp_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        dp_crc  = crc16_step(dp_crc, b);
        dp_seen = dp_seen + 8'd1;
        if (dp_seen >= dp_len) dp_phase = PH_CRC_HI;
        frame_out_q.push_back('{kind: KIND_DATA, data: b, status: ST_OK, len: 8'd0,
                                last: 1'b0});
      end
      PH_CRC_HI: begin
        dp_crc_hi = b;
        dp_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({dp_crc_hi, b} != dp_crc) begin
          r.status = ST_CRC;
          frame_out_q.push_back(r);
          drop_frame();
        end else begin
          dp_phase = PH_STOP;
        end
      end
      PH_STOP: begin
        r.status = (b == STOP_BYTE) ? ST_OK : ST_STOP;
        frame_out_q.push_back(r);
        drop_frame();
      end
      default: drop_frame();
    endcase
  endfunction

  // Compare one result transfer with the oldest pending one
  function automatic void check_frame_out();
    frame_out_t e;
    if (frame_out_q.size() == 0) begin
      err_cnt++;
      $error("result with nothing pending: kind %0d data %0h status %0d",
             kind_o, data_byte_o, status_o);
      return;
    end
    e = frame_out_q.pop_front();
    if (kind_o !== e.kind) begin
      err_cnt++;
      $error("kind: expected %0d, actual %0d", e.kind, kind_o);
    end
    if (data_byte_o !== e.data) begin
      err_cnt++;
      $error("data_byte: expected %0h, actual %0h", e.data, data_byte_o);
    end
    if (status_o !== e.status) begin
      err_cnt++;
      $error("status: expected %0d, actual %0d", e.status, status_o);
    end
    if (frame_length_o !== e.len) begin
      err_cnt++;
      $error("frame_length: expected %0d, actual %0d", e.len, frame_length_o);
    end
    if (last_o !== e.last) begin
      err_cnt++;
      $error("last: expected %0d, actual %0d", e.last, last_o);
    end
  endfunction

  // Byte driver: predict on each transfer, then present the next byte or idle
  always @(posedge clk_i) begin : rx_driver
    logic free;
    if (rst_ni) begin
      free = !rx_valid_i;
      if (rx_valid_i && !rx_stall_o) begin
        deframe_byte(rx_byte_i);
        free = 1'b1;
      end
      if (free) begin
        if (rx_gap != 0) begin
          rx_gap--;
          rx_valid_i <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          if ($urandom_range(99, 0) < idle_pct) begin
            rx_gap = $urandom_range(13, 0);
            rx_valid_i <= 1'b0;
          end else begin
            rx_valid_i <= 1'b1;
            rx_byte_i  <= rx_bytes_q.pop_front();
          end
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stall bursts
  always @(posedge clk_i) begin : tx_monitor
    if (rst_ni) begin
      if (tx_valid_o && !tx_stall_i) check_frame_out();
      if (tx_gap != 0) begin
        tx_gap--;
        tx_stall_i <= 1'b1;
      end else if ($urandom_range(99, 0) < idle_pct) begin
        tx_gap = $urandom_range(13, 0);
        tx_stall_i <= 1'b1;
      end else begin
        tx_stall_i <= 1'b0;
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((rx_valid_i && !rx_stall_o) || (tx_valid_o && !tx_stall_i) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAX_PAYLOAD: cfg_max  = value[7:0];
      REG_CRC_POLY:    cfg_poly = value[15:0];
      REG_CRC_INIT:    cfg_init = value[15:0];
      default: ;
    endcase
  endtask

  // Hold until every byte is taken and every result has arrived, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk_i); while (rx_bytes_q.size() != 0 || rx_valid_i || frame_out_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Queue one frame; fill < 0 gives random payload bytes
  task automatic push_frame(int unsigned len, frame_fault_e fault, int fill);
    logic [7:0]  tail[$];
    logic [7:0]  d;
    logic [15:0] crc;
    int unsigned keep;
    rx_bytes_q.push_back(START_BYTE);
    rx_bytes_q.push_back(len[7:0]);
    if (fault == FR_BAD_LEN) return;
    crc = cfg_init;
    for (int unsigned i = 0; i < len; i++) begin
      d = (fill < 0) ? 8'($urandom_range(255, 0)) : 8'(fill);
      crc = crc16_step(crc, d);
      tail.push_back(d);
    end
    tail.push_back(crc[15:8]);
    tail.push_back(crc[7:0]);
    tail.push_back(STOP_BYTE);
    case (fault)
      FR_BAD_CRC: begin
        tail[len + $urandom_range(1, 0)] ^= 8'(1 << $urandom_range(7, 0));
        void'(tail.pop_back());
      end
      FR_BAD_STOP: tail[len + 2] = STOP_BYTE ^ 8'($urandom_range(255, 1));
      default: ;
    endcase
    keep = (fault == FR_CUT) ? $urandom_range(len + 2, 0) : tail.size();
    for (int unsigned i = 0; i < keep; i++) rx_bytes_q.push_back(tail[i]);
  endtask

  // Mostly well-formed frames, some corrupt or cut short, some line noise
  task automatic push_random_frame();
    int unsigned pick;
    int unsigned top;
    int unsigned len;
    pick = $urandom_range(99, 0);
    top  = (cfg_max == 0 || cfg_max > 12) ? 12 : cfg_max;
    len  = $urandom_range(top, 1);
    if (pick < 60) begin
      push_frame(len, FR_GOOD, -1);
    end else if (pick < 68) begin
      push_frame(len, FR_BAD_CRC, -1);
    end else if (pick < 76) begin
      push_frame(len, FR_BAD_STOP, -1);
    end else if (pick < 84) begin
      if (cfg_max == 255 || $urandom_range(1, 0) == 0) len = 0;
      else len = $urandom_range(255, cfg_max + 1);
      push_frame(len, FR_BAD_LEN, -1);
    end else if (pick < 92) begin
      push_frame(len, FR_CUT, -1);
    end else begin
      repeat ($urandom_range(3, 1)) rx_bytes_q.push_back(8'($urandom_range(255, 0)));
    end
  endtask

  // One register setting: write all registers, hit the length limits, then random frames
  task automatic run_setting(logic [7:0] max_len, logic [15:0] poly, logic [15:0] init,
                             int unsigned budget, int unsigned pct, bit longest);
    int unsigned base;
    idle_pct = pct;
    write_reg(REG_MAX_PAYLOAD, {24'd0, max_len});
    write_reg(REG_CRC_POLY, {16'd0, poly});
    write_reg(REG_CRC_INIT, {16'd0, init});
    @(negedge clk_i);
    if (max_len != 0 && max_len <= 40) push_frame(max_len, FR_GOOD, -1);
    if (max_len != 255) push_frame(max_len + 1, FR_BAD_LEN, -1);
    if (longest) push_frame(255, FR_GOOD, -1);
    base = rx_bytes_q.size();
    while (rx_bytes_q.size() - base < budget) push_random_frame();
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: noise in hunt, clean frame, zero length, CRC error, bad stop
    idle_pct = 10;
    @(negedge clk_i);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(STOP_BYTE);
    push_frame(1, FR_GOOD, 255);
    push_frame(0, FR_BAD_LEN, -1);
    push_frame(1, FR_BAD_CRC, 0);
    push_frame(1, FR_BAD_STOP, 8'hAA);
    wait_drained();

    // Zero max payload rejects every length
    run_setting(8'd0, 16'h1021, 16'h0000, 30, 20, 1'b0);
    run_setting(8'd1, 16'h8005, 16'hFFFF, 120, 25, 1'b0);
    run_setting(8'd255, 16'hFFFF, 16'h0000, 120, 0, 1'b0);
    run_setting(8'd16, 16'h0000, 16'h1234, 120, 15, 1'b0);
    run_setting(8'd200, 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                120, 30, 1'b0);
    // Final stretch without idling, back at reset values, longest payload included
    run_setting(MAX_PAYLOAD_RST, CRC_POLY_RST, CRC_INIT_RST, 120, 0, 1'b1);

    repeat (8) @(negedge clk_i);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/spd_pkg.sv
sv/spd_front.sv
sv/spd_fifo.sv
sv/spd_back.sv
sv/short_packet_deframer_crc16.sv
tb/short_packet_deframer_crc16_tb.sv
